[hw/rtl/bsns_pkg.sv]
// Shared constants, request codes, state type and interface structs of the bitmap store.
package bsns_pkg;

    localparam int WORD_BITS = 64;
    localparam int NUM_WORDS = 64;
    localparam int SUB_W     = $clog2(WORD_BITS);
    localparam int ADDR_W    = $clog2(NUM_WORDS);
    localparam int IDX_W     = 12;
    localparam int LIM_W     = 13;
    localparam int TYPE_W    = 3;
    localparam int BYTE_W    = 8;
    localparam int BYTE_SW   = $clog2(BYTE_W);
    localparam int GRP_N     = WORD_BITS / BYTE_W;
    localparam int GRP_W     = $clog2(GRP_N);

    localparam logic [LIM_W-1:0] INDEX_SPACE = LIM_W'(2 ** IDX_W);

    typedef logic [TYPE_W-1:0] req_kind_t;

    localparam req_kind_t REQ_TEST  = TYPE_W'(0);
    localparam req_kind_t REQ_SET   = TYPE_W'(1);
    localparam req_kind_t REQ_CLEAR = TYPE_W'(2);
    localparam req_kind_t REQ_OR    = TYPE_W'(3);
    localparam req_kind_t REQ_FIND  = TYPE_W'(4);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_OP,
        ST_FBIT
    } state_t;

    typedef struct packed {
        logic                 we;
        logic [ADDR_W-1:0]    waddr;
        logic [WORD_BITS-1:0] wdata;
        logic [ADDR_W-1:0]    raddr;
    } mem_req_t;

    typedef struct packed {
        logic             load;
        logic [SUB_W-1:0] lo_sub;
        logic [SUB_W-1:0] hi_sub;
        logic             use_hi;
    } find_ctl_t;

endpackage

[hw/rtl/bitmap_store_with_next_set_scan.sv]
// Top level of the bitmap store with test, set, clear, word OR and find-next-set requests.
//
// A transaction is accepted at a rising edge where start is high and busy is low. The
// request fields are sampled at that edge. Each transaction gives exactly one result on
// found, position and next_start, valid for the single cycle in which done is high.
// The receiver cannot stall; results are never held back.
// Test, set, clear and OR word read the addressed word from the store at the accepting edge
// and answer or write back from ST_OP, which they pass through once; the result is
// registered as the block returns to ST_IDLE.
// A find walks the words from the start word to the last word below the limit, one
// store read per word through the find unit, and locates the bit inside a hit word
// in the extra state ST_FBIT.
// The single-port word read of the store sets the scan rate of one word per cycle.
// A new transaction may be started while the previous result is on the outputs.
// Reset clears the whole store at once through per-word valid bits; no clearing
// pass is needed and the block is ready as soon as reset is released.
module bitmap_store_with_next_set_scan (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [bsns_pkg::TYPE_W-1:0]    req_type,
    input  logic [bsns_pkg::IDX_W-1:0]     bit_index,
    input  logic [bsns_pkg::ADDR_W-1:0]    word_index,
    input  logic [bsns_pkg::WORD_BITS-1:0] word_value,
    input  logic [bsns_pkg::LIM_W-1:0]     scan_limit,
    output logic                           done,
    output logic                           found,
    output logic [bsns_pkg::IDX_W-1:0]     position,
    output logic [bsns_pkg::LIM_W-1:0]     next_start
);
    import bsns_pkg::*;

    mem_req_t             mem_req;
    find_ctl_t            find_ctl;
    logic [WORD_BITS-1:0] rd_data;
    logic                 hit;
    logic [SUB_W-1:0]     bit_off;

    bsns_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req_type   (req_type),
        .bit_index  (bit_index),
        .word_index (word_index),
        .word_value (word_value),
        .scan_limit (scan_limit),
        .done       (done),
        .found      (found),
        .position   (position),
        .next_start (next_start),
        .mem_req    (mem_req),
        .rd_data    (rd_data),
        .find_ctl   (find_ctl),
        .hit        (hit),
        .bit_off    (bit_off)
    );

    bsns_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    bsns_find u_find (
        .clk     (clk),
        .ctl     (find_ctl),
        .rd_data (rd_data),
        .hit     (hit),
        .bit_off (bit_off)
    );

endmodule

[hw/rtl/bsns_store.sv]
// Word memory of the bitmap with per-word valid bits so that unwritten words read as zero.
module bsns_store (
    input  logic                           clk,
    input  logic                           rst_n,
    input  bsns_pkg::mem_req_t             req,
    output logic [bsns_pkg::WORD_BITS-1:0] rd_data
);
    import bsns_pkg::*;

    logic [WORD_BITS-1:0] mem [NUM_WORDS];
    logic [WORD_BITS-1:0] q_reg;
    logic                 q_valid_reg;
    logic [NUM_WORDS-1:0] valid_reg;
    logic [NUM_WORDS-1:0] valid_next;

    always_comb
    begin
        valid_next = valid_reg;
        if (req.we)
        begin
            valid_next[req.waddr] = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        q_reg <= mem[req.raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            q_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg   <= valid_next;
            q_valid_reg <= valid_reg[req.raddr];
        end
    end

    assign rd_data = q_valid_reg ? q_reg : '0;

endmodule

[hw/rtl/bsns_find.sv]
// Find unit: masks one word to the scan window and locates its lowest set bit in two steps.
module bsns_find (
    input  logic                           clk,
    input  bsns_pkg::find_ctl_t            ctl,
    input  logic [bsns_pkg::WORD_BITS-1:0] rd_data,
    output logic                           hit,
    output logic [bsns_pkg::SUB_W-1:0]     bit_off
);
    import bsns_pkg::*;

    logic [WORD_BITS-1:0] logical;
    logic [WORD_BITS-1:0] mask_lo;
    logic [WORD_BITS-1:0] mask_hi;
    logic [WORD_BITS-1:0] masked;
    logic [GRP_W-1:0]     grp_sel;
    logic [BYTE_W-1:0]    grp_byte;
    logic [GRP_W-1:0]     grp_reg;
    logic [BYTE_W-1:0]    byte_reg;
    logic [BYTE_SW-1:0]   bit_sel;

    always_comb
    begin
        for (int k = 0; k < WORD_BITS; k++)
        begin
            logical[k] = rd_data[WORD_BITS-1-k];
        end
        mask_lo = {WORD_BITS{1'b1}} << ctl.lo_sub;
        mask_hi = ctl.use_hi ? ({WORD_BITS{1'b1}} >> (SUB_W'(WORD_BITS - 1) - ctl.hi_sub))
                             : {WORD_BITS{1'b1}};
        masked  = logical & mask_lo & mask_hi;
        hit     = |masked;
    end

    always_comb
    begin
        grp_sel  = '0;
        grp_byte = '0;
        for (int g = GRP_N - 1; g >= 0; g--)
        begin
            if (|masked[g*BYTE_W +: BYTE_W])
            begin
                grp_sel = GRP_W'(g);
            end
        end
        for (int g = 0; g < GRP_N; g++)
        begin
            if (grp_sel == GRP_W'(g))
            begin
                grp_byte = masked[g*BYTE_W +: BYTE_W];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            grp_reg  <= grp_sel;
            byte_reg <= grp_byte;
        end
    end

    always_comb
    begin
        bit_sel = '0;
        for (int b = BYTE_W - 1; b >= 0; b--)
        begin
            if (byte_reg[b])
            begin
                bit_sel = BYTE_SW'(b);
            end
        end
        bit_off = {grp_reg, bit_sel};
    end

endmodule

[hw/rtl/bsns_seq.sv]
// Request sequencer: decodes each transaction, drives the store and the find unit, registers results.
module bsns_seq (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [bsns_pkg::TYPE_W-1:0]    req_type,
    input  logic [bsns_pkg::IDX_W-1:0]     bit_index,
    input  logic [bsns_pkg::ADDR_W-1:0]    word_index,
    input  logic [bsns_pkg::WORD_BITS-1:0] word_value,
    input  logic [bsns_pkg::LIM_W-1:0]     scan_limit,
    output logic                           done,
    output logic                           found,
    output logic [bsns_pkg::IDX_W-1:0]     position,
    output logic [bsns_pkg::LIM_W-1:0]     next_start,
    output bsns_pkg::mem_req_t             mem_req,
    input  logic [bsns_pkg::WORD_BITS-1:0] rd_data,
    output bsns_pkg::find_ctl_t            find_ctl,
    input  logic                           hit,
    input  logic [bsns_pkg::SUB_W-1:0]     bit_off
);
    import bsns_pkg::*;

    state_t               state_reg, state_next;
    req_kind_t            kind_reg, kind_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [WORD_BITS-1:0] wval_reg, wval_next;
    logic [LIM_W-1:0]     limit_reg, limit_next;
    logic [LIM_W-1:0]     end_reg, end_next;
    logic [ADDR_W-1:0]    word_reg, word_next;
    logic                 done_reg, done_next;
    logic                 found_reg, found_next;
    logic [IDX_W-1:0]     pos_reg, pos_next;
    logic [LIM_W-1:0]     nxt_reg, nxt_next;

    logic [SUB_W-1:0]     idx_sub;
    logic [ADDR_W-1:0]    start_word;
    logic [LIM_W-1:0]     end_m1;
    logic [ADDR_W-1:0]    last_word;
    logic                 scan_empty;
    logic                 at_last;
    logic [WORD_BITS-1:0] bit_mask;

    assign idx_sub    = idx_reg[SUB_W-1:0];
    assign start_word = idx_reg[IDX_W-1:SUB_W];
    assign end_m1     = end_reg - LIM_W'(1);
    assign last_word  = end_m1[IDX_W-1:SUB_W];
    assign scan_empty = {1'b0, idx_reg} >= end_reg;
    assign at_last    = word_reg == last_word;
    assign bit_mask   = {{(WORD_BITS-1){1'b0}}, 1'b1} << (SUB_W'(WORD_BITS - 1) - idx_sub);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_OP;
                end
            end
            ST_OP:
            begin
                if (kind_reg == REQ_FIND && !scan_empty && hit)
                begin
                    state_next = ST_FBIT;
                end
                else if (kind_reg == REQ_FIND && !scan_empty && !at_last)
                begin
                    state_next = ST_OP;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FBIT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        kind_next  = kind_reg;
        idx_next   = idx_reg;
        wval_next  = wval_reg;
        limit_next = limit_reg;
        end_next   = end_reg;
        word_next  = word_reg;
        done_next  = 1'b0;
        found_next = 1'b0;
        pos_next   = '0;
        nxt_next   = '0;

        mem_req.we    = 1'b0;
        mem_req.waddr = word_reg;
        mem_req.wdata = rd_data;
        mem_req.raddr = word_reg;

        find_ctl.load   = 1'b0;
        find_ctl.lo_sub = (word_reg == start_word) ? idx_sub : '0;
        find_ctl.hi_sub = end_m1[SUB_W-1:0];
        find_ctl.use_hi = at_last;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    kind_next  = req_type;
                    idx_next   = bit_index;
                    wval_next  = word_value;
                    limit_next = scan_limit;
                    end_next   = (scan_limit > INDEX_SPACE) ? INDEX_SPACE : scan_limit;
                    word_next  = (req_type == REQ_OR) ? word_index
                                                      : bit_index[IDX_W-1:SUB_W];
                end
                mem_req.raddr = word_next;
            end
            ST_OP:
            begin
                case (kind_reg)
                    REQ_TEST:
                    begin
                        done_next  = 1'b1;
                        found_next = rd_data[SUB_W'(WORD_BITS - 1) - idx_sub];
                    end
                    REQ_SET:
                    begin
                        done_next     = 1'b1;
                        mem_req.we    = 1'b1;
                        mem_req.wdata = rd_data | bit_mask;
                    end
                    REQ_CLEAR:
                    begin
                        done_next     = 1'b1;
                        mem_req.we    = 1'b1;
                        mem_req.wdata = rd_data & ~bit_mask;
                    end
                    REQ_OR:
                    begin
                        done_next     = 1'b1;
                        mem_req.we    = 1'b1;
                        mem_req.wdata = rd_data | wval_reg;
                    end
                    REQ_FIND:
                    begin
                        if (scan_empty)
                        begin
                            done_next = 1'b1;
                            nxt_next  = limit_reg;
                        end
                        else if (hit)
                        begin
                            find_ctl.load = 1'b1;
                        end
                        else if (at_last)
                        begin
                            done_next = 1'b1;
                            nxt_next  = limit_reg;
                        end
                        else
                        begin
                            word_next     = word_reg + ADDR_W'(1);
                            mem_req.raddr = word_next;
                        end
                    end
                    default:
                    begin
                        done_next = 1'b1;
                    end
                endcase
            end
            ST_FBIT:
            begin
                done_next  = 1'b1;
                found_next = 1'b1;
                pos_next   = {word_reg, bit_off};
                nxt_next   = {1'b0, pos_next} + LIM_W'(1);
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        idx_reg   <= idx_next;
        wval_reg  <= wval_next;
        limit_reg <= limit_next;
        end_reg   <= end_next;
        word_reg  <= word_next;
        found_reg <= found_next;
        pos_reg   <= pos_next;
        nxt_reg   <= nxt_next;
    end

    assign busy       = state_reg != ST_IDLE;
    assign done       = done_reg;
    assign found      = found_reg;
    assign position   = pos_reg;
    assign next_start = nxt_reg;

    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(state_reg) == ST_OP || $past(state_reg) == ST_FBIT))
        else $error("result strobe without a finishing request");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && state_reg == ST_IDLE) |=> state_reg == ST_OP)
        else $error("accepted transaction did not start work");

    a_fbit_find: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FBIT |-> (kind_reg == REQ_FIND && $past(hit)))
        else $error("bit locate step without a hit in a find");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && !found_reg) |-> pos_reg == '0)
        else $error("position nonzero on a miss");

    a_write_rmw: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.we |-> (state_reg == ST_OP && kind_reg != REQ_FIND))
        else $error("store written outside a modify request");

endmodule

[sim/tb_bitmap_store_with_next_set_scan.sv]
// Self-checking testbench of the bitmap store with test, set, clear, word OR and find-next-set.
module tb_bitmap_store_with_next_set_scan;

    timeunit 1ns;
    timeprecision 1ps;

    import bsns_pkg::*;

    localparam int          MAX_CYCLES  = 1_000_000;
    localparam int          DRAIN_WAIT  = 80;
    localparam int          RANDOM_REQS = 2000;
    localparam int          RECENT_MAX  = 64;
    localparam req_kind_t   REQ_BAD_LO  = req_kind_t'(REQ_FIND + 1);
    localparam req_kind_t   REQ_BAD_HI  = '1;

    typedef struct packed {
        req_kind_t            kind;
        logic [IDX_W-1:0]     idx;
        logic [ADDR_W-1:0]    widx;
        logic [WORD_BITS-1:0] wval;
        logic [LIM_W-1:0]     limit;
    } bitmap_req_t;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] position;
        logic [LIM_W-1:0] next_start;
    } scan_result_t;

    logic                 clk;
    logic                 rst_n      = 1'b0;
    logic                 start      = 1'b0;
    logic                 busy;
    logic [TYPE_W-1:0]    req_type   = '0;
    logic [IDX_W-1:0]     bit_index  = '0;
    logic [ADDR_W-1:0]    word_index = '0;
    logic [WORD_BITS-1:0] word_value = '0;
    logic [LIM_W-1:0]     scan_limit = '0;
    logic                 done;
    logic                 found;
    logic [IDX_W-1:0]     position;
    logic [LIM_W-1:0]     next_start;

    logic [WORD_BITS-1:0] model_words [NUM_WORDS];
    scan_result_t         expected_q [$];
    int unsigned          recent_bits [$];
    int                   error_count = 0;
    int                   cycle_count = 0;
    bit                   no_idle     = 1'b0;

    bitmap_store_with_next_set_scan dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req_type   (req_type),
        .bit_index  (bit_index),
        .word_index (word_index),
        .word_value (word_value),
        .scan_limit (scan_limit),
        .done       (done),
        .found      (found),
        .position   (position),
        .next_start (next_start)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic model_bit(input int unsigned n);
        int unsigned w;
        int unsigned s;
        w = n / WORD_BITS;
        s = n % WORD_BITS;
        if (w >= NUM_WORDS)
            return 1'b0;
        return model_words[w][WORD_BITS-1-s];
    endfunction

    function automatic void model_put_bit(input int unsigned n, input logic v);
        int unsigned w;
        int unsigned s;
        w = n / WORD_BITS;
        s = n % WORD_BITS;
        if (w < NUM_WORDS)
            model_words[w][WORD_BITS-1-s] = v;
    endfunction

    function automatic scan_result_t apply_request(input bitmap_req_t r);
        scan_result_t res;
        int unsigned  stop;
        res = '0;
        case (r.kind)
            REQ_TEST:  res.found = model_bit(r.idx);
            REQ_SET:   model_put_bit(r.idx, 1'b1);
            REQ_CLEAR: model_put_bit(r.idx, 1'b0);
            REQ_OR:
            begin
                if (r.widx < NUM_WORDS)
                    model_words[r.widx] = model_words[r.widx] | r.wval;
            end
            REQ_FIND:
            begin
                res.next_start = r.limit;
                stop = (r.limit < INDEX_SPACE) ? r.limit : INDEX_SPACE;
                for (int unsigned i = r.idx; i < stop; i++)
                begin
                    if (model_bit(i))
                    begin
                        res.found      = 1'b1;
                        res.position   = IDX_W'(i);
                        res.next_start = LIM_W'(i + 1);
                        break;
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic logic [WORD_BITS-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // Drives one transaction, holding start high across back-to-back transactions.
    task automatic issue(input req_kind_t kind, input int unsigned idx,
                         input int unsigned widx, input logic [WORD_BITS-1:0] wval,
                         input int unsigned limit);
        bitmap_req_t r;
        int          gap;
        r.kind  = kind;
        r.idx   = IDX_W'(idx);
        r.widx  = ADDR_W'(widx);
        r.wval  = wval;
        r.limit = LIM_W'(limit);
        gap     = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_type   <= r.kind;
        bit_index  <= r.idx;
        word_index <= r.widx;
        word_value <= r.wval;
        scan_limit <= r.limit;
        start      <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        expected_q.push_back(apply_request(r));
    endtask

    task automatic test_single_bits();
        issue(REQ_TEST, 0, $urandom, rand_word(), $urandom);
        issue(REQ_SET, 0, $urandom, rand_word(), $urandom);
        issue(REQ_SET, 4095, $urandom, rand_word(), $urandom);
        issue(REQ_TEST, 0, $urandom, rand_word(), $urandom);
        issue(REQ_TEST, 4095, $urandom, rand_word(), $urandom);
        issue(REQ_CLEAR, 0, $urandom, rand_word(), $urandom);
        issue(REQ_TEST, 0, $urandom, rand_word(), $urandom);
    endtask

    task automatic test_word_or();
        issue(REQ_OR, $urandom, NUM_WORDS - 1, 64'h8000_0000_0000_0001, $urandom);
        issue(REQ_OR, $urandom, 1, '1, $urandom);
        issue(REQ_OR, $urandom, 2, '0, $urandom);
        issue(REQ_TEST, WORD_BITS, $urandom, rand_word(), $urandom);
        issue(REQ_TEST, 4095, $urandom, rand_word(), $urandom);
    endtask

    task automatic test_find_edges();
        issue(REQ_FIND, 0, $urandom, rand_word(), INDEX_SPACE);
        issue(REQ_FIND, 65, $urandom, rand_word(), 8191);
        issue(REQ_FIND, 200, $urandom, rand_word(), 100);
        issue(REQ_FIND, 128, $urandom, rand_word(), 128);
        issue(REQ_FIND, 4000, $urandom, rand_word(), 4095);
        issue(REQ_FIND, 4033, $urandom, rand_word(), 4095);
        issue(REQ_FIND, 4033, $urandom, rand_word(), INDEX_SPACE);
        issue(REQ_FIND, 0, $urandom, rand_word(), 0);
    endtask

    task automatic test_unknown_requests();
        for (int k = REQ_BAD_LO; k <= REQ_BAD_HI; k++)
            issue(req_kind_t'(k), $urandom, $urandom, rand_word(), $urandom);
    endtask

    function automatic int unsigned pick_index();
        if (recent_bits.size() > 0 && $urandom_range(0, 1) == 1)
            return recent_bits[$urandom_range(0, recent_bits.size() - 1)];
        return $urandom_range(0, 4095);
    endfunction

    task automatic test_random_mix();
        int unsigned          sel;
        int unsigned          idx;
        int unsigned          limit;
        logic [WORD_BITS-1:0] wval;
        for (int n = 0; n < RANDOM_REQS; n++)
        begin
            if (n % 100 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            sel = $urandom_range(0, 99);
            idx = pick_index();
            if (sel < 25)
            begin
                issue(REQ_SET, idx, $urandom, rand_word(), $urandom);
                recent_bits.push_back(idx);
                if (recent_bits.size() > RECENT_MAX)
                    void'(recent_bits.pop_front());
            end
            else if (sel < 40)
                issue(REQ_CLEAR, idx, $urandom, rand_word(), $urandom);
            else if (sel < 60)
                issue(REQ_TEST, idx, $urandom, rand_word(), $urandom);
            else if (sel < 66)
            begin
                if ($urandom_range(0, 7) == 0)
                    wval = rand_word();
                else
                    wval = rand_word() & rand_word() & rand_word() & rand_word();
                issue(REQ_OR, $urandom, $urandom, wval, $urandom);
            end
            else if (sel < 95)
            begin
                case ($urandom_range(0, 3))
                    0:       limit = $urandom_range(0, 8191);
                    1:       limit = idx + $urandom_range(0, 300);
                    2:       limit = INDEX_SPACE;
                    default: limit = 8191;
                endcase
                issue(REQ_FIND, idx, $urandom, rand_word(), limit);
            end
            else
                issue(req_kind_t'($urandom_range(REQ_BAD_LO, REQ_BAD_HI)), $urandom,
                      $urandom, rand_word(), $urandom);
        end
    endtask

    always @(posedge clk)
    begin
        scan_result_t exp_res;
        if (rst_n && done)
        begin
            if (expected_q.size() == 0)
            begin
                $display("%0t ERROR unexpected result: expected none actual %0h/%0h/%0h",
                         $time, found, position, next_start);
                error_count++;
            end
            else
            begin
                exp_res = expected_q.pop_front();
                if (found !== exp_res.found)
                begin
                    $display("%0t ERROR found: expected %0h actual %0h",
                             $time, exp_res.found, found);
                    error_count++;
                end
                if (position !== exp_res.position)
                begin
                    $display("%0t ERROR position: expected %0d actual %0d",
                             $time, exp_res.position, position);
                    error_count++;
                end
                if (next_start !== exp_res.next_start)
                begin
                    $display("%0t ERROR next_start: expected %0d actual %0d",
                             $time, exp_res.next_start, next_start);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > MAX_CYCLES)
        begin
            $display("%0t ERROR timeout with %0d results outstanding",
                     $time, expected_q.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        foreach (model_words[i])
            model_words[i] = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        test_single_bits();
        test_word_or();
        test_find_edges();
        test_unknown_requests();
        test_random_mix();
        @(posedge clk);
        start <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/bsns_pkg.sv
hw/rtl/bsns_store.sv
hw/rtl/bsns_find.sv
hw/rtl/bsns_seq.sv
hw/rtl/bitmap_store_with_next_set_scan.sv
sim/tb_bitmap_store_with_next_set_scan.sv
